/* hdl/message_parameter_tokenizer_macros.svh */
// Assertion macros used by the checker file.
`ifndef MESSAGE_PARAMETER_TOKENIZER_MACROS_SVH
`define MESSAGE_PARAMETER_TOKENIZER_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define MPT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define MPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/mpt_pkg.sv */
// ----------------------------------------------------------------------------
// mpt_pkg
// Types and constants shared by the message parameter tokenizer.
// ----------------------------------------------------------------------------
package mpt_pkg;

   localparam logic [7:0] COLON_BYTE    = 8'h3A;
   localparam logic [7:0] SPACE_BYTE    = 8'h20;
   localparam logic [7:0] DELIM_RESET   = 8'h20;
   localparam int         MAX_RESULTS   = 4;
   localparam int         SLOT_W        = $clog2(MAX_RESULTS);
   localparam int         QDEPTH        = 2;
   localparam int         QPTR_W        = $clog2(QDEPTH);
   localparam int         QCNT_W        = $clog2(QDEPTH + 1);

   typedef enum logic [1:0] {
      KIND_OPEN = 2'd0,
      KIND_DATA = 2'd1,
      KIND_END  = 2'd2
   } kind_type;

   typedef logic [9:0] rep_type;
   typedef logic [3:0] tok_type;
   typedef logic [SLOT_W-1:0] slot_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] out_byte;
      rep_type    repeat_res;
      tok_type    token_index;
      logic       any_tokens;
   } res_type;

   // All results caused by one request, in order, and the index of the last.
   typedef struct packed {
      res_type [MAX_RESULTS-1:0] slots;
      slot_type                  last;
   } cmd_type;

endpackage

/* hdl/mpt_front.sv */
// ----------------------------------------------------------------------------
// mpt_front
// Classifies each message byte, updates the token state and builds the list
// of results that the byte causes.
// ----------------------------------------------------------------------------
module mpt_front #(
   parameter int MAX_TOKENS  = 16,
   parameter int MAX_PENDING = 1023
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       msg_byte,
   input  logic             end_of_message,
   input  logic             csr_we,
   input  logic [7:0]       csr_wdata,
   output logic             cmd_push,
   output mpt_pkg::cmd_type cmd
);

   localparam int TW = $clog2(MAX_TOKENS);
   localparam int PW = $clog2(MAX_PENDING + 1);
   localparam logic [TW-1:0] TokMax  = TW'(MAX_TOKENS - 1);
   localparam logic [PW-1:0] PendMax = PW'(MAX_PENDING);

   typedef enum logic [1:0] {
      PH_BETWEEN  = 2'd0,
      PH_PLAIN    = 2'd1,
      PH_TRAILING = 2'd2
   } phase_type;

   phase_type     phase_ff, phase_in;
   logic [TW-1:0] token_ff, token_in;
   logic          opened_ff, opened_in;
   logic [PW-1:0] pend_ff, pend_in;
   logic [7:0]    delim_ff;

   mpt_pkg::res_type [mpt_pkg::MAX_RESULTS-1:0] slots;
   logic [2:0] n;

   function automatic mpt_pkg::res_type mk_res(
      mpt_pkg::kind_type kind,
      logic [7:0]        b,
      logic [PW-1:0]     rep,
      logic [TW-1:0]     idx,
      logic              any
   );
      mpt_pkg::res_type r;
      r.kind        = kind;
      r.out_byte    = b;
      r.repeat_res  = mpt_pkg::rep_type'(rep);
      r.token_index = mpt_pkg::tok_type'(idx);
      r.any_tokens  = any;
      return r;
   endfunction

   always_comb begin
      logic is_delim;
      logic do_open;
      logic do_content;
      phase_in   = phase_ff;
      token_in   = token_ff;
      opened_in  = opened_ff;
      pend_in    = pend_ff;
      slots      = '0;
      n          = 3'd0;
      is_delim   = (msg_byte == delim_ff);
      do_open    = 1'b0;
      do_content = 1'b0;

      unique case (phase_ff)
         PH_TRAILING: do_content = 1'b1;
         PH_PLAIN: begin
            if (is_delim) begin
               phase_in = PH_BETWEEN;
            end else begin
               do_content = 1'b1;
            end
         end
         default: begin
            if (!is_delim) begin
               do_open = 1'b1;
               if (msg_byte == mpt_pkg::COLON_BYTE) begin
                  phase_in = PH_TRAILING;
               end else begin
                  phase_in   = PH_PLAIN;
                  do_content = 1'b1;
               end
            end
         end
      endcase

      if (do_open) begin
         // release spaces held over from the previous token
         if (pend_in != '0) begin
            slots[n[1:0]] = mk_res(mpt_pkg::KIND_DATA, mpt_pkg::SPACE_BYTE, pend_in,
                                   token_in, 1'b0);
            n       = n + 3'd1;
            pend_in = '0;
         end
         if (!opened_in) begin
            opened_in = 1'b1;
            token_in  = '0;
         end else if (token_in < TokMax) begin
            token_in = token_in + 1'b1;
         end
         slots[n[1:0]] = mk_res(mpt_pkg::KIND_OPEN, 8'd0, '0, token_in, 1'b0);
         n = n + 3'd1;
      end

      if (do_content) begin
         if (msg_byte == mpt_pkg::SPACE_BYTE) begin
            pend_in = pend_in + 1'b1;
            // flush a full counter as data
            if (pend_in == PendMax) begin
               slots[n[1:0]] = mk_res(mpt_pkg::KIND_DATA, mpt_pkg::SPACE_BYTE, pend_in,
                                      token_in, 1'b0);
               n       = n + 3'd1;
               pend_in = '0;
            end
         end else begin
            if (pend_in != '0) begin
               slots[n[1:0]] = mk_res(mpt_pkg::KIND_DATA, mpt_pkg::SPACE_BYTE, pend_in,
                                      token_in, 1'b0);
               n       = n + 3'd1;
               pend_in = '0;
            end
            slots[n[1:0]] = mk_res(mpt_pkg::KIND_DATA, msg_byte, PW'(1), token_in, 1'b0);
            n = n + 3'd1;
         end
      end

      if (end_of_message) begin
         slots[n[1:0]] = mk_res(mpt_pkg::KIND_END, 8'd0, '0,
                                opened_in ? token_in : '0, opened_in);
         n         = n + 3'd1;
         phase_in  = PH_BETWEEN;
         token_in  = '0;
         opened_in = 1'b0;
         pend_in   = '0;
      end
   end

   assign cmd.slots = slots;
   assign cmd.last  = mpt_pkg::slot_type'(n - 3'd1);
   assign cmd_push  = accept && (n != 3'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_BETWEEN;
         token_ff  <= '0;
         opened_ff <= 1'b0;
         pend_ff   <= '0;
         delim_ff  <= mpt_pkg::DELIM_RESET;
      end else begin
         if (accept) begin
            phase_ff  <= phase_in;
            token_ff  <= token_in;
            opened_ff <= opened_in;
            pend_ff   <= pend_in;
         end
         if (csr_we) begin
            delim_ff <= csr_wdata;
         end
      end
   end

endmodule

/* hdl/mpt_queue.sv */
// ----------------------------------------------------------------------------
// mpt_queue
// Short command queue between the classifier and the result serializer.
// ----------------------------------------------------------------------------
module mpt_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mpt_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output mpt_pkg::cmd_type pop_data,
   output logic             empty
);

   mpt_pkg::cmd_type                  mem_ff [mpt_pkg::QDEPTH];
   logic [mpt_pkg::QPTR_W-1:0]        wr_ptr_ff;
   logic [mpt_pkg::QPTR_W-1:0]        rd_ptr_ff;
   logic [mpt_pkg::QCNT_W-1:0]        count_ff;
   logic                              do_push, do_pop;

   localparam logic [mpt_pkg::QCNT_W-1:0] Depth = mpt_pkg::QCNT_W'(mpt_pkg::QDEPTH);
   localparam logic [mpt_pkg::QPTR_W-1:0] LastPtr = mpt_pkg::QPTR_W'(mpt_pkg::QDEPTH - 1);

   assign full     = (count_ff == Depth);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

/* hdl/mpt_back.sv */
// ----------------------------------------------------------------------------
// mpt_back
// Walks the result slots of each queued command and presents them one at a
// time in the output register.
// ----------------------------------------------------------------------------
module mpt_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  mpt_pkg::cmd_type cmd,
   output logic             cmd_pop,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output mpt_pkg::res_type rsp_res,
   output logic             rsp_last_result
);

   mpt_pkg::slot_type slot_ff;
   logic              valid_ff;
   mpt_pkg::res_type  res_ff;
   logic              last_ff;
   logic              load;
   logic              at_last;

   assign load      = cmd_valid && (!valid_ff || rsp_pop);
   assign at_last   = (slot_ff == cmd.last);
   assign cmd_pop   = load && at_last;
   assign rsp_empty = !valid_ff;
   assign rsp_res   = res_ff;
   assign rsp_last_result = last_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff  <= cmd.slots[slot_ff];
         last_ff <= at_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         slot_ff  <= '0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            // advance to the next slot, or back to the first on the last one
            slot_ff  <= at_last ? '0 : slot_ff + 1'b1;
         end else if (rsp_pop) begin
            valid_ff <= 1'b0;
         end
      end
   end

endmodule

/* hdl/message_parameter_tokenizer.sv */
// ----------------------------------------------------------------------------
// message_parameter_tokenizer
// Splits a byte stream into tokens on a programmable delimiter.
// ----------------------------------------------------------------------------
// A request is taken whenever the two-entry command queue has room, so
// requests may arrive back to back. Each request yields zero to four
// results; the serializer sends one result per cycle from its output
// register while each result is popped, so the sustained request rate is
// set by that serializer. A result held on the rsp_ ports does not block
// new requests until the queue fills.
module message_parameter_tokenizer #(
   parameter int MAX_TOKENS  = 16,
   parameter int MAX_PENDING = 1023
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_msg_byte,
   input  logic       req_end_of_message,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic [9:0] rsp_repeat_res,
   output logic [3:0] rsp_token_index,
   output logic       rsp_any_tokens,
   output logic       rsp_last_result,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata
);

   logic             accept;
   logic             cmd_push;
   mpt_pkg::cmd_type cmd_in;
   mpt_pkg::cmd_type cmd_head;
   logic             q_empty;
   logic             cmd_pop;
   mpt_pkg::res_type res;

   assign accept = req_push && !req_full;

   mpt_front #(
      .MAX_TOKENS  (MAX_TOKENS),
      .MAX_PENDING (MAX_PENDING)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .msg_byte       (req_msg_byte),
      .end_of_message (req_end_of_message),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .cmd_push       (cmd_push),
      .cmd            (cmd_in)
   );

   mpt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (req_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_head),
      .empty     (q_empty)
   );

   mpt_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (!q_empty),
      .cmd             (cmd_head),
      .cmd_pop         (cmd_pop),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_res         (res),
      .rsp_last_result (rsp_last_result)
   );

   assign rsp_kind        = res.kind;
   assign rsp_out_byte    = res.out_byte;
   assign rsp_repeat_res  = res.repeat_res;
   assign rsp_token_index = res.token_index;
   assign rsp_any_tokens  = res.any_tokens;

endmodule

/* hdl/mpt_checker.sv */
// ----------------------------------------------------------------------------
// mpt_checker
// Port-level checks on the tokenizer's result stream.
// ----------------------------------------------------------------------------
`include "message_parameter_tokenizer_macros.svh"

module mpt_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_out_byte,
   input logic [9:0] rsp_repeat_res,
   input logic [3:0] rsp_token_index,
   input logic       rsp_any_tokens,
   input logic       rsp_last_result
);

   `MPT_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, rsp_empty, "result after reset")
   `MPT_ASSERT_NEXT(a_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_kind) && $stable(rsp_out_byte) && $stable(rsp_repeat_res) && $stable(rsp_last_result), "held result changed")
   `MPT_ASSERT_NOW(a_end_last, clock, reset, !rsp_empty && rsp_kind == mpt_pkg::KIND_END, rsp_last_result, "message end not last result")
   `MPT_ASSERT_NOW(a_no_data_zero, clock, reset, !rsp_empty && rsp_kind != mpt_pkg::KIND_DATA, rsp_out_byte == 8'd0 && rsp_repeat_res == 10'd0, "non-data result carries data")
   `MPT_ASSERT_NOW(a_none_index, clock, reset, !rsp_empty && !rsp_any_tokens, rsp_token_index == 4'd0 || rsp_kind != mpt_pkg::KIND_END, "empty message with index")

endmodule

bind message_parameter_tokenizer mpt_checker u_mpt_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_empty       (rsp_empty),
   .rsp_pop         (rsp_pop),
   .rsp_kind        (rsp_kind),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_repeat_res  (rsp_repeat_res),
   .rsp_token_index (rsp_token_index),
   .rsp_any_tokens  (rsp_any_tokens),
   .rsp_last_result (rsp_last_result)
);
